// ----- hdl/sace_pkg.sv -----
// ----------------------------------------------------------------------------
// sace_pkg
// Shared constants, codes and control/status types of the size-aware
// cache eviction table.
// ----------------------------------------------------------------------------
`default_nettype none

package sace_pkg;

  localparam int SLOTS      = 64;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int SCNT_W     = $clog2(SLOTS + 1);
  localparam int KEY_W      = 32;
  localparam int LEN_W      = 21;
  localparam int TICK_W     = 48;
  localparam int UCNT_W     = 32;
  localparam int BYTES_W    = 32;
  localparam int EVC_W      = 7;
  localparam int SLOT_OUT_W = 6;
  localparam int MODE_W     = 2;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PUT    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PROBE  = 2'd2;

  localparam logic [POL_W-1:0] POL_LRU = 2'd0;
  localparam logic [POL_W-1:0] POL_LFU = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'b1;

  localparam logic [BYTES_W-1:0] CAPACITY_RESET = 32'd65536;

  typedef struct packed {
    logic start;
    logic scan_find;
    logic scan_victim;
    logic drop_match;
    logic evict;
    logic touch;
    logic write_new;
    logic load_out;
    logic put_ok;
  } sace_cmd_t;

  typedef struct packed {
    logic              scan_done;
    logic              found;
    logic              best_valid;
    logic              fits;
    logic              free_avail;
    logic [MODE_W-1:0] mode;
  } sace_sts_t;

endpackage

`default_nettype wire

// ----- hdl/sace_req_if.sv -----
// ----------------------------------------------------------------------------
// sace_req_if
// Request channel: operation, key and length with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface sace_req_if
  import sace_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  item_key;
  logic [LEN_W-1:0]  item_length;

  modport source (output valid, mode, item_key, item_length, input ready);
  modport sink   (input valid, mode, item_key, item_length, output ready);
endinterface

`default_nettype wire

// ----- hdl/sace_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sace_rsp_if
// Result channel: hit/stored flag, slot, length, evictions and bytes in use.
// ----------------------------------------------------------------------------
`default_nettype none

interface sace_rsp_if
  import sace_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  success;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [LEN_W-1:0]      stored_length;
  logic [EVC_W-1:0]      evictions;
  logic [BYTES_W-1:0]    bytes_in_use;

  modport source (output valid, success, slot_index, stored_length, evictions,
                  bytes_in_use, input ready);
  modport sink   (input valid, success, slot_index, stored_length, evictions,
                  bytes_in_use, output ready);
endinterface

`default_nettype wire

// ----- hdl/sace_dp.sv -----
// ----------------------------------------------------------------------------
// sace_dp
// Datapath: slot table memories, valid bits, sequential slot scan for key
// match, free slot and victim, byte accounting and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sace_dp
  import sace_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [KEY_W-1:0]      in_key,
  input  wire logic [LEN_W-1:0]      in_length,
  input  wire sace_cmd_t             cmd,
  output sace_sts_t                  sts,
  output logic                       out_success,
  output logic [SLOT_OUT_W-1:0]      out_slot_index,
  output logic [LEN_W-1:0]           out_stored_length,
  output logic [EVC_W-1:0]           out_evictions,
  output logic [BYTES_W-1:0]         out_bytes_in_use
);

  logic [KEY_W-1:0]  key_mem   [SLOTS];
  logic [LEN_W-1:0]  len_mem   [SLOTS];
  logic [TICK_W-1:0] stamp_mem [SLOTS];
  logic [UCNT_W-1:0] cnt_mem   [SLOTS];

  logic [SLOTS-1:0]   valid_r;
  logic [BYTES_W-1:0] cap_r;
  logic [POL_W-1:0]   pol_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [TICK_W-1:0]  tick_r;

  logic [MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [LEN_W-1:0]  len_r;
  logic [EVC_W-1:0]  evc_r;

  logic              scan_act_r, scan_vict_r, rd_vld_r, scan_done_r;
  logic [SCNT_W-1:0] iss_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [IDX_W-1:0]  rd_addr;

  logic [KEY_W-1:0]  key_rd;
  logic [LEN_W-1:0]  len_rd;
  logic [TICK_W-1:0] stamp_rd;
  logic [UCNT_W-1:0] cnt_rd;

  logic              found_r, free_avail_r, best_valid_r;
  logic [IDX_W-1:0]  match_idx_r, free_idx_r, best_idx_r;
  logic [LEN_W-1:0]  match_len_r, best_len_r;
  logic [UCNT_W-1:0] match_cnt_r, best_cnt_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [TICK_W-1:0] best_stamp_r;

  logic              rd_v, better, fits;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  drop_idx;

  logic                  out_success_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [LEN_W-1:0]      out_len_r;
  logic [EVC_W-1:0]      out_evc_r;
  logic [BYTES_W-1:0]    out_bytes_r;

  assign rd_addr  = iss_r[IDX_W-1:0];
  assign rd_v     = valid_r[rd_idx_r];
  assign wr_addr  = cmd.touch ? match_idx_r : free_idx_r;
  assign drop_idx = cmd.evict ? best_idx_r : match_idx_r;
  assign fits     = ({1'b0, bytes_r} + (BYTES_W + 1)'(len_r)) <= {1'b0, cap_r};

  always_comb begin
    case (pol_r)
      POL_LRU: better = (stamp_rd < best_stamp_r) ||
                        ((stamp_rd == best_stamp_r) && (key_rd < best_key_r));
      POL_LFU: better = (cnt_rd < best_cnt_r) ||
                        ((cnt_rd == best_cnt_r) && (key_rd < best_key_r));
      default: better = key_rd < best_key_r;
    endcase
  end

  // table memories: one read port driven by the scan, one write port
  always_ff @(posedge clk) begin
    key_rd   <= key_mem[rd_addr];
    len_rd   <= len_mem[rd_addr];
    stamp_rd <= stamp_mem[rd_addr];
    cnt_rd   <= cnt_mem[rd_addr];
    if (cmd.write_new) begin
      key_mem[wr_addr] <= key_r;
      len_mem[wr_addr] <= len_r;
    end
    if (cmd.write_new || cmd.touch) begin
      stamp_mem[wr_addr] <= tick_r;
    end
    if (cmd.write_new) begin
      cnt_mem[wr_addr] <= '0;
    end else if (cmd.touch) begin
      cnt_mem[wr_addr] <= (&match_cnt_r) ? match_cnt_r : match_cnt_r + 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cap_r       <= CAPACITY_RESET;
      pol_r       <= POL_LRU;
      bytes_r     <= '0;
      tick_r      <= '0;
      scan_act_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r <= cfg_wdata[BYTES_W-1:0];
          CFG_POLICY:   pol_r <= cfg_wdata[POL_W-1:0];
          default:      ;
        endcase
      end
      if (cmd.start) begin
        tick_r <= tick_r + 1'b1;
      end
      if (cmd.start || cmd.scan_victim) begin
        scan_act_r <= 1'b1;
      end else if (scan_act_r && (iss_r == SCNT_W'(SLOTS - 1))) begin
        scan_act_r <= 1'b0;
      end
      rd_vld_r    <= scan_act_r;
      scan_done_r <= rd_vld_r && (rd_idx_r == IDX_W'(SLOTS - 1));
      if (cmd.drop_match || cmd.evict) begin
        valid_r[drop_idx] <= 1'b0;
        bytes_r <= bytes_r - BYTES_W'(cmd.evict ? best_len_r : match_len_r);
      end else if (cmd.write_new) begin
        valid_r[free_idx_r] <= 1'b1;
        bytes_r <= bytes_r + BYTES_W'(len_r);
      end
    end
  end

  // scan bookkeeping and result registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r       <= in_mode;
      key_r        <= in_key;
      len_r        <= in_length;
      evc_r        <= '0;
      found_r      <= 1'b0;
      free_avail_r <= 1'b0;
    end
    if (cmd.start || cmd.scan_victim) begin
      iss_r       <= '0;
      scan_vict_r <= cmd.scan_victim;
      best_valid_r <= 1'b0;
    end else if (scan_act_r) begin
      iss_r <= iss_r + 1'b1;
    end
    rd_idx_r <= rd_addr;
    if (rd_vld_r && !scan_vict_r) begin
      if (rd_v && (key_rd == key_r) && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= rd_idx_r;
        match_len_r <= len_rd;
        match_cnt_r <= cnt_rd;
      end
      if (!rd_v && !free_avail_r) begin
        free_avail_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
    if (rd_vld_r && scan_vict_r && rd_v && (!best_valid_r || better)) begin
      best_valid_r <= 1'b1;
      best_idx_r   <= rd_idx_r;
      best_len_r   <= len_rd;
      best_cnt_r   <= cnt_rd;
      best_key_r   <= key_rd;
      best_stamp_r <= stamp_rd;
    end
    // a dropped slot may become the lowest free one
    if (cmd.drop_match || cmd.evict) begin
      if (!free_avail_r || (drop_idx < free_idx_r)) begin
        free_avail_r <= 1'b1;
        free_idx_r   <= drop_idx;
      end
    end
    if (cmd.evict && !(&evc_r)) begin
      evc_r <= evc_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_success_r <= 1'b0;
      out_slot_r    <= '0;
      out_len_r     <= '0;
      out_evc_r     <= evc_r;
      out_bytes_r   <= bytes_r;
      case (mode_r)
        MODE_LOOKUP: begin
          if (found_r) begin
            out_success_r <= 1'b1;
            out_slot_r    <= SLOT_OUT_W'(match_idx_r);
            out_len_r     <= match_len_r;
          end
        end
        MODE_PROBE: begin
          out_success_r <= found_r;
        end
        MODE_PUT: begin
          if (cmd.put_ok) begin
            out_success_r <= 1'b1;
            out_slot_r    <= SLOT_OUT_W'(free_idx_r);
            out_len_r     <= len_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign sts.scan_done  = scan_done_r;
  assign sts.found      = found_r;
  assign sts.best_valid = best_valid_r;
  assign sts.fits       = fits;
  assign sts.free_avail = free_avail_r;
  assign sts.mode       = mode_r;

  assign out_success       = out_success_r;
  assign out_slot_index    = out_slot_r;
  assign out_stored_length = out_len_r;
  assign out_evictions     = out_evc_r;
  assign out_bytes_in_use  = out_bytes_r;

endmodule

`default_nettype wire

// ----- hdl/sace_ctrl.sv -----
// ----------------------------------------------------------------------------
// sace_ctrl
// Controller: sequences key search, touch, drop, victim searches, evictions
// and the insert, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module sace_ctrl
  import sace_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire sace_sts_t sts,
  output sace_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_TOUCH, S_DROP, S_CHECK, S_VICT, S_EVICT, S_WRITE, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   put_ok_r, put_ok_nxt;

  always_comb begin
    state_nxt     = state_r;
    put_ok_nxt    = put_ok_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.put_ok    = put_ok_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          put_ok_nxt = 1'b0;
          state_nxt  = S_FIND;
        end
      end
      S_FIND: begin
        if (sts.scan_done) begin
          case (sts.mode)
            MODE_LOOKUP: state_nxt = sts.found ? S_TOUCH : S_FINISH;
            MODE_PUT:    state_nxt = sts.found ? S_DROP : S_CHECK;
            default:     state_nxt = S_FINISH;
          endcase
        end
      end
      S_TOUCH: begin
        cmd.touch = 1'b1;
        state_nxt = S_FINISH;
      end
      S_DROP: begin
        cmd.drop_match = 1'b1;
        state_nxt      = S_CHECK;
      end
      S_CHECK: begin
        if (sts.fits && sts.free_avail) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.scan_victim = 1'b1;
          state_nxt       = S_VICT;
        end
      end
      S_VICT: begin
        if (sts.scan_done) begin
          state_nxt = sts.best_valid ? S_EVICT : S_FINISH;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_CHECK;
      end
      S_WRITE: begin
        cmd.write_new = 1'b1;
        put_ok_nxt    = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      put_ok_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      put_ok_r    <= put_ok_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hdl/size_aware_cache_eviction_top.sv -----
// ----------------------------------------------------------------------------
// size_aware_cache_eviction_top
// Fully associative keyed table under a byte budget with LRU, LFU or
// lowest-key eviction.
// ----------------------------------------------------------------------------
// One transaction at a time. Every operation scans the table once, one slot
// per cycle through the single read port of the slot memories, and a put
// adds another full scan for every victim search. A finished result waits
// in an output register, so the next transaction is accepted while it is
// still pending. No clearing pass after reset; slot valid bits are cleared
// at once.
`default_nettype none

module size_aware_cache_eviction_top
  import sace_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  sace_req_if.sink                   in_ch,
  sace_rsp_if.source                 out_ch
);

  sace_cmd_t cmd;
  sace_sts_t sts;

  sace_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sace_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (in_ch.mode),
    .in_key            (in_ch.item_key),
    .in_length         (in_ch.item_length),
    .cmd               (cmd),
    .sts               (sts),
    .out_success       (out_ch.success),
    .out_slot_index    (out_ch.slot_index),
    .out_stored_length (out_ch.stored_length),
    .out_evictions     (out_ch.evictions),
    .out_bytes_in_use  (out_ch.bytes_in_use)
  );

  // busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while a transaction is in flight");

  a_scan_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |=> !sts.scan_done)
    else $error("scan done held longer than one cycle");

  a_one_table_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.touch, cmd.write_new, cmd.drop_match, cmd.evict}))
    else $error("conflicting table updates in one cycle");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- sim/size_aware_cache_eviction_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_aware_cache_eviction_top_tb
// Self-checking bench for the size-aware cache eviction table. A queue fed
// driver offers lookups, puts and probes in bursts, a stalling receiver
// takes results, and an in-bench model of the keyed table predicts every
// result field. Budget and victim policy are changed between phases while
// the block is idle.
// ----------------------------------------------------------------------------
module size_aware_cache_eviction_top_tb;
  import sace_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNDEF = 2'd3;
  localparam logic [POL_W-1:0]  POL_KEY_LO = 2'd2;
  localparam logic [POL_W-1:0]  POL_KEY_HI = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD      = 400;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  item_key;
    logic [LEN_W-1:0]  item_length;
  } cache_op_t;

  typedef struct packed {
    logic                  success;
    logic [SLOT_OUT_W-1:0] slot_index;
    logic [LEN_W-1:0]      stored_length;
    logic [EVC_W-1:0]      evictions;
    logic [BYTES_W-1:0]    bytes_in_use;
  } cache_rsp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sace_req_if in_ch ();
  sace_rsp_if out_ch ();

  size_aware_cache_eviction_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Table model
  logic              tbl_valid [SLOTS];
  logic [KEY_W-1:0]  tbl_key   [SLOTS];
  logic [LEN_W-1:0]  tbl_len   [SLOTS];
  logic [TICK_W-1:0] tbl_stamp [SLOTS];
  logic [UCNT_W-1:0] tbl_uses  [SLOTS];
  logic [BYTES_W-1:0] tbl_bytes;
  logic [TICK_W-1:0]  tbl_tick;
  logic [BYTES_W-1:0] budget;
  logic [POL_W-1:0]   policy;

  cache_op_t  pending_ops [$];
  cache_rsp_t expected_rsps [$];

  int  errors = 0;
  int  ops_sent = 0;
  int  rsps_seen = 0;
  int  hits = 0;
  int  evict_total = 0;
  int  put_fails = 0;
  bit  req_taken = 0;
  bit  hold_input = 0;
  int  burst_left = 4;
  int  gap_left = 0;
  int  hold_requests = 0;
  int  hold_served = 0;
  int  hold_count = 0;
  int  stall_style = 0;
  int  style_left = 0;
  int  idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int pick_victim();
    int  best;
    bit  better;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) continue;
      if (best < 0) begin
        best = i;
        continue;
      end
      if (policy == POL_LRU)
        better = tbl_stamp[i] < tbl_stamp[best] ||
                 (tbl_stamp[i] == tbl_stamp[best] && tbl_key[i] < tbl_key[best]);
      else if (policy == POL_LFU)
        better = tbl_uses[i] < tbl_uses[best] ||
                 (tbl_uses[i] == tbl_uses[best] && tbl_key[i] < tbl_key[best]);
      else
        better = tbl_key[i] < tbl_key[best];
      if (better) best = i;
    end
    return best;
  endfunction

  function automatic int first_free();
    for (int i = 0; i < SLOTS; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  task automatic predict_cache_op(input cache_op_t op, output cache_rsp_t rsp);
    int s;
    int v;
    int evicted;
    bit ok;
    rsp = '0;
    evicted = 0;
    ok = 1'b1;
    tbl_tick = tbl_tick + 1'b1;
    case (op.mode)
      MODE_LOOKUP: begin
        s = find_slot(op.item_key);
        if (s >= 0) begin
          if (tbl_uses[s] != '1) tbl_uses[s] = tbl_uses[s] + 1'b1;
          tbl_stamp[s] = tbl_tick;
          rsp.success = 1'b1;
          rsp.slot_index = s[SLOT_OUT_W-1:0];
          rsp.stored_length = tbl_len[s];
        end
      end
      MODE_PROBE: begin
        if (find_slot(op.item_key) >= 0) rsp.success = 1'b1;
      end
      MODE_PUT: begin
        s = find_slot(op.item_key);
        // release the old copy; not an eviction
        if (s >= 0) begin
          tbl_valid[s] = 1'b0;
          tbl_bytes = tbl_bytes - tbl_len[s];
        end
        forever begin
          s = first_free();
          if ({1'b0, tbl_bytes} + op.item_length <= {1'b0, budget} && s >= 0) break;
          v = pick_victim();
          if (v < 0) begin
            ok = 1'b0;
            break;
          end
          tbl_valid[v] = 1'b0;
          tbl_bytes = tbl_bytes - tbl_len[v];
          evicted++;
        end
        if (ok) begin
          tbl_valid[s] = 1'b1;
          tbl_key[s] = op.item_key;
          tbl_len[s] = op.item_length;
          tbl_stamp[s] = tbl_tick;
          tbl_uses[s] = '0;
          tbl_bytes = tbl_bytes + op.item_length;
          rsp.success = 1'b1;
          rsp.slot_index = s[SLOT_OUT_W-1:0];
          rsp.stored_length = op.item_length;
        end
        rsp.evictions = (evicted > 127) ? 7'd127 : evicted[EVC_W-1:0];
      end
      default: ;
    endcase
    rsp.bytes_in_use = tbl_bytes;
  endtask

  // Driver: offer the head of the pending queue, in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !req_taken) begin
      // hold until accepted
    end else begin
      req_taken = 1'b0;
      if (gap_left > 0 || hold_input || pending_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_ch.valid <= 1'b1;
        in_ch.mode <= pending_ops[0].mode;
        in_ch.item_key <= pending_ops[0].item_key;
        in_ch.item_length <= pending_ops[0].item_length;
      end
    end
  end

  // Receiver: stall on its own pattern, with a long hold when requested
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_count = LONG_HOLD;
    end
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 2);
      style_left = $urandom_range(20, 120);
    end else begin
      style_left--;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_ch.ready <= 1'b0;
    end else if (stall_style == 0) begin
      out_ch.ready <= 1'b1;
    end else if (stall_style == 1) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ch.ready <= ($urandom_range(0, 1) != 0);
    end
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    cache_op_t  op;
    cache_rsp_t got;
    cache_rsp_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      got.success = out_ch.success;
      got.slot_index = out_ch.slot_index;
      got.stored_length = out_ch.stored_length;
      got.evictions = out_ch.evictions;
      got.bytes_in_use = out_ch.bytes_in_use;
      rsps_seen++;
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = expected_rsps.pop_front();
        if (got.success !== want.success || got.slot_index !== want.slot_index ||
            got.stored_length !== want.stored_length ||
            got.evictions !== want.evictions ||
            got.bytes_in_use !== want.bytes_in_use) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      moved = 1'b1;
      op.mode = in_ch.mode;
      op.item_key = in_ch.item_key;
      op.item_length = in_ch.item_length;
      void'(pending_ops.pop_front());
      predict_cache_op(op, want);
      if (op.mode != MODE_PUT && want.success) hits++;
      if (op.mode == MODE_PUT && !want.success) put_fails++;
      evict_total += want.evictions;
      expected_rsps.push_back(want);
      ops_sent++;
      req_taken = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_rsps.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_op(input logic [MODE_W-1:0] m, input logic [KEY_W-1:0] k,
                          input logic [LEN_W-1:0] len);
    cache_op_t op;
    op.mode = m;
    op.item_key = k;
    op.item_length = len;
    pending_ops.push_back(op);
  endtask

  // send everything queued, then hold the sender until every result is back
  task automatic drain_all();
    do @(negedge clk);
    while (pending_ops.size() != 0 || in_ch.valid);
    hold_input = 1'b1;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_CAPACITY) budget = data;
    else policy = data[POL_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int count, input int key_base);
    logic [MODE_W-1:0] m;
    logic [KEY_W-1:0]  k;
    logic [LEN_W-1:0]  len;
    int                pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      m = pick < 45 ? MODE_PUT : pick < 75 ? MODE_LOOKUP : pick < 95 ? MODE_PROBE
                                                                      : MODE_UNDEF;
      k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom())
                                      : KEY_W'(key_base + $urandom_range(0, 79));
      pick = $urandom_range(0, 99);
      if (pick < 85) len = LEN_W'($urandom_range(0, 2000));
      else if (pick < 95) len = LEN_W'($urandom_range(0, 1048576));
      else len = ($urandom_range(0, 1) != 0) ? 21'd1048576 : 21'd0;
      queue_op(m, k, len);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] caps [6];
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    tbl_bytes = '0;
    tbl_tick = '0;
    budget = CAPACITY_RESET;
    policy = POL_LRU;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOOKUP;
    in_ch.item_key = '0;
    in_ch.item_length = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: misses, undefined mode, failing put, re-put, LRU eviction
    queue_op(MODE_PROBE, 32'h0, 21'd0);
    queue_op(MODE_LOOKUP, 32'hFFFF_FFFF, 21'd0);
    queue_op(MODE_UNDEF, 32'h1234_5678, 21'd1048576);
    queue_op(MODE_PUT, 32'h0, 21'd0);
    queue_op(MODE_PUT, 32'hFFFF_FFFF, 21'd1048576);
    queue_op(MODE_LOOKUP, 32'h0, 21'd0);
    queue_op(MODE_PUT, 32'd5, 21'd100);
    queue_op(MODE_PUT, 32'd6, 21'd200);
    queue_op(MODE_PUT, 32'd5, 21'd300);
    queue_op(MODE_LOOKUP, 32'd5, 21'd0);
    queue_op(MODE_LOOKUP, 32'd5, 21'h0F_FFFF);
    queue_op(MODE_PROBE, 32'd6, 21'd0);
    queue_op(MODE_LOOKUP, 32'd6, 21'd0);
    queue_op(MODE_PUT, 32'd7, 21'd65136);
    queue_op(MODE_PUT, 32'hAAAA_AAAA, 21'h0A_AAAA);
    queue_op(MODE_PUT, 32'h5555_5555, 21'h15_5555);
    queue_op(MODE_PROBE, 32'hAAAA_AAAA, 21'd0);
    drain_all();

    // big entry stored under the largest budget
    write_reg(CFG_CAPACITY, 32'hFFFF_FFFF);
    hold_input = 1'b0;
    queue_op(MODE_PUT, 32'h5555_5555, 21'd1048576);
    queue_op(MODE_LOOKUP, 32'h5555_5555, 21'd0);
    drain_all();

    caps[0] = 32'hFFFF_FFFF;
    caps[1] = 32'd3000;
    caps[2] = 32'd0;
    caps[3] = 32'd1048576;
    caps[4] = 32'd20000;
    caps[5] = CAPACITY_RESET;
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_POLICY, ph[POL_W-1:0]);
      write_reg(CFG_CAPACITY, caps[ph]);
      hold_input = 1'b0;
      queue_random(32, ph * 40);
      if (ph == 1) hold_requests++;
      // pause mid-phase until every result is back
      if (ph == 3) drain_all();
      hold_input = 1'b0;
      queue_random(32, ph * 40);
      drain_all();
    end

    repeat (100) @(negedge clk);
    $display("Covered %0d operations under 4 policies and 6 budgets: %0d hits,", ops_sent,
             hits);
    $display("%0d evictions, %0d failed puts, %0d results checked", evict_total, put_fails,
             rsps_seen);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/sace_pkg.sv
hdl/sace_req_if.sv
hdl/sace_rsp_if.sv
hdl/sace_dp.sv
hdl/sace_ctrl.sv
hdl/size_aware_cache_eviction_top.sv
sim/size_aware_cache_eviction_top_tb.sv
